@@ design/slcd_pkg.sv @@
// Shared types, character codes and decimal-field helpers for the serial
// light command decoder. No dependencies.

package slcd_pkg;

  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [7:0] END_MARK   = 8'd35;   // '#'
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_BANG  = 8'h21;
  localparam logic [7:0] CHAR_QUERY = 8'h3F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] KEY_LIGHT  = 8'h6C;   // 'l'
  localparam logic [7:0] KEY_BRIGHT = 8'h62;   // 'b'
  localparam logic [7:0] KEY_MODE   = 8'h6D;   // 'm'
  localparam logic [7:0] KEY_DIM    = 8'h64;   // 'd'

  localparam logic [7:0]  FLOOR_RST      = 8'd10;
  localparam logic [7:0]  CEILING_RST    = 8'd120;
  localparam logic [7:0]  BRIGHTNESS_RST = 8'd50;
  localparam logic [7:0]  MODE_RST       = 8'd1;
  localparam logic [23:0] COLOUR_RST     = 24'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS_FLOOR   = 4'd0,
    REG_BRIGHTNESS_CEILING = 4'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    REPLY_OK   = 2'd0,
    REPLY_NOK  = 2'd1,
    REPLY_INFO = 2'd2
  } reply_t;

  typedef struct packed {
    logic [7:0] floor_lvl;
    logic [7:0] ceiling_lvl;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } stage_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [9:0] digit_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - CHAR_ZERO;
    return {6'd0, d[3:0]};
  endfunction

  // Value of the leading digits of a three-character field, 0..999.
  function automatic logic [9:0] dec3(input logic [7:0] c0, input logic [7:0] c1,
                                      input logic [7:0] c2);
    logic [9:0] v;
    if (!is_digit(c0)) begin
      v = 10'd0;
    end else if (!is_digit(c1)) begin
      v = digit_val(c0);
    end else if (!is_digit(c2)) begin
      v = digit_val(c0) * 10'd10 + digit_val(c1);
    end else begin
      v = digit_val(c0) * 10'd100 + digit_val(c1) * 10'd10 + digit_val(c2);
    end
    return v;
  endfunction

  function automatic logic [7:0] clamp255(input logic [9:0] v);
    return (v > 10'd255) ? 8'hFF : v[7:0];
  endfunction

endpackage

@@ design/slcd_ifs.sv @@
// Channel interfaces of the serial light command decoder: received bytes,
// results and configuration writes. Depends on slcd_pkg.

interface slcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcd_res_if;
  import slcd_pkg::*;
  logic        valid;
  logic        ready;
  reply_t      reply;
  logic [23:0] colour;
  logic [7:0]  brightness;
  logic [7:0]  light_mode;
  logic        dimmed;
  logic        host_waiting;
  modport source (output valid, output reply, output colour, output brightness,
                  output light_mode, output dimmed, output host_waiting, input ready);
  modport sink (input valid, input reply, input colour, input brightness,
                input light_mode, input dimmed, input host_waiting, output ready);
endinterface

interface slcd_cfg_if;
  import slcd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ design/slcd_cfg_regs.sv @@
// Brightness floor and ceiling registers behind the configuration channel.
// Depends on slcd_pkg and slcd_cfg_if.

module slcd_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  slcd_cfg_if.sink      cfg_if,
  output slcd_pkg::cfg_t cfg
);
  import slcd_pkg::*;

  logic [7:0] floor_r;
  logic [7:0] ceiling_r;

  assign cfg_if.ready = 1'b1;
  assign cfg.floor_lvl   = floor_r;
  assign cfg.ceiling_lvl = ceiling_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r   <= FLOOR_RST;
      ceiling_r <= CEILING_RST;
    end else if (cfg_if.valid) begin
      // drop writes to unknown indexes
      case (cfg_if.index)
        REG_BRIGHTNESS_FLOOR:   floor_r   <= cfg_if.wdata;
        REG_BRIGHTNESS_CEILING: ceiling_r <= cfg_if.wdata;
        default: ;
      endcase
    end
  end

endmodule

@@ design/slcd_in_stage.sv @@
// Input register for received bytes; frees the rx side from result stalls.
// Depends on slcd_pkg and slcd_rx_if.

module slcd_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  slcd_rx_if.sink         in_if,
  input  logic            take,
  output slcd_pkg::stage_t stage
);
  import slcd_pkg::*;

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_if.ready   = !valid_r || take;
  assign stage.valid   = valid_r;
  assign stage.rx_byte = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_if.ready) begin
      valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      byte_r <= in_if.rx_byte;
    end
  end

endmodule

@@ design/slcd_core.sv @@
// Command buffer, decode of a finished command, stored light settings and
// the result register. Depends on slcd_pkg and slcd_res_if.

module slcd_core #(
  parameter int unsigned BUFFER_LEN = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  slcd_pkg::stage_t stage,
  input  slcd_pkg::cfg_t   cfg,
  output logic             take,
  slcd_res_if.source       out_if
);
  import slcd_pkg::*;

  localparam int unsigned FILL_W = $clog2(BUFFER_LEN + 1);
  localparam int unsigned IDX_W  = $clog2(BUFFER_LEN);

  logic [7:0]        buf_r [BUFFER_LEN];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [23:0]       colour_r, colour_nxt;
  logic [7:0]        bright_r, bright_nxt;
  logic [7:0]        mode_r, mode_nxt;
  logic              dim_r, dim_nxt;
  logic              waiting_r, waiting_nxt;

  logic              out_valid_r;
  reply_t            reply_r, reply_nxt;
  logic              emit;
  logic              is_end;
  logic              full;
  logic [7:0]        view [BUFFER_LEN];
  logic [9:0]        f0, f1, f2;
  logic [7:0]        cmd_type, cmd_key;

  assign take   = stage.valid && (!out_valid_r || out_if.ready);
  assign is_end = (stage.rx_byte == END_MARK);
  assign full   = (fill_r == FILL_W'(BUFFER_LEN));
  assign emit   = is_end || full;

  // Bytes past the fill count read as zero, so a clear only resets the count.
  always_comb begin
    for (int i = 0; i < BUFFER_LEN; i++) begin
      view[i] = (FILL_W'(i) < fill_r) ? buf_r[i] : 8'd0;
    end
  end

  assign cmd_type = view[0];
  assign cmd_key  = view[1];
  assign f0 = dec3(view[2], view[3], view[4]);
  assign f1 = dec3(view[5], view[6], view[7]);
  assign f2 = dec3(view[8], view[9], view[10]);

  always_comb begin
    colour_nxt  = colour_r;
    bright_nxt  = bright_r;
    mode_nxt    = mode_r;
    dim_nxt     = dim_r;
    waiting_nxt = waiting_r;
    reply_nxt   = REPLY_NOK;
    fill_nxt    = emit ? '0 : fill_r + FILL_W'(1);
    if (is_end) begin
      if (cmd_type == CHAR_MINUS) begin
        if (cmd_key == CHAR_BANG) begin
          reply_nxt = REPLY_INFO;
        end else if (cmd_key == CHAR_QUERY) begin
          reply_nxt = REPLY_OK;
        end
      end else if (cmd_type == CHAR_PLUS) begin
        reply_nxt = REPLY_OK;
        case (cmd_key)
          KEY_LIGHT:  colour_nxt = {clamp255(f0), clamp255(f1), clamp255(f2)};
          KEY_BRIGHT: begin
            if (f0 < {2'b00, cfg.floor_lvl}) begin
              bright_nxt = cfg.floor_lvl;
            end else if (f0 > {2'b00, cfg.ceiling_lvl}) begin
              bright_nxt = cfg.ceiling_lvl;
            end else begin
              bright_nxt = f0[7:0];
            end
          end
          KEY_MODE:   mode_nxt = f0[7:0];
          KEY_DIM:    dim_nxt = is_digit(view[2]) && (view[2] != CHAR_ZERO);
          default:    reply_nxt = REPLY_NOK;
        endcase
      end
      if (reply_nxt == REPLY_OK) begin
        waiting_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      colour_r    <= COLOUR_RST;
      bright_r    <= BRIGHTNESS_RST;
      mode_r      <= MODE_RST;
      dim_r       <= 1'b0;
      waiting_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        fill_r    <= fill_nxt;
        colour_r  <= colour_nxt;
        bright_r  <= bright_nxt;
        mode_r    <= mode_nxt;
        dim_r     <= dim_nxt;
        waiting_r <= waiting_nxt;
      end
      if (take) begin
        out_valid_r <= emit;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !emit) begin
      buf_r[fill_r[IDX_W-1:0]] <= stage.rx_byte;
    end
  end

  // Result payload: stores as they stand after the command.
  always_ff @(posedge clk) begin
    if (take && emit) begin
      reply_r           <= reply_nxt;
      out_if.colour     <= colour_nxt;
      out_if.brightness <= bright_nxt;
      out_if.light_mode <= mode_nxt;
      out_if.dimmed     <= dim_nxt;
      out_if.host_waiting <= waiting_nxt;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.reply = reply_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(BUFFER_LEN))
    else $error("fill count past buffer length");

  a_wait_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !waiting_r |=> !waiting_r)
    else $error("host waiting flag set again after an ok reply");

  a_ok_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (reply_r == REPLY_OK) |-> !out_if.host_waiting)
    else $error("ok result still shows host waiting");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && emit |=> fill_r == '0)
    else $error("buffer not cleared after a result");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |=> out_valid_r && $stable(reply_r))
    else $error("waiting result lost or changed");

endmodule

@@ design/serial_light_command_decoder.sv @@
// Top level of the serial light command decoder: input register, decode core
// and configuration registers. Depends on slcd_pkg, the slcd interfaces and submodules.
//
//   channel   direction  payload
//   in_if     sink       rx_byte (8)
//   out_if    source     reply (2), colour (24), brightness (8), light_mode (8),
//                        dimmed (1), host_waiting (1)
//   cfg_if    sink       index (4), wdata (8); 0 brightness floor, 1 ceiling
//
// One byte per cycle while no result stalls on out_if.ready; out_if.valid rises
// once its '#' or overflow byte has passed the input register and result register.
// Reset (rst_n low at a clock edge) empties the buffer and restores the stores.
// While a result waits on out_if.ready, the input register takes at most one more
// byte, then in_if.ready drops until the result is taken.
// Configuration writes are taken every cycle and only make sense while idle.

module serial_light_command_decoder #(
  parameter int unsigned BUFFER_LEN = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  slcd_rx_if.sink     in_if,
  slcd_res_if.source  out_if,
  slcd_cfg_if.sink    cfg_if
);
  import slcd_pkg::*;

  cfg_t   cfg;
  stage_t stage;
  logic   take;

  slcd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  slcd_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .take  (take),
    .stage (stage)
  );

  slcd_core #(
    .BUFFER_LEN (BUFFER_LEN)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .stage  (stage),
    .cfg    (cfg),
    .take   (take),
    .out_if (out_if)
  );

endmodule
